// ===== rtl/pei_pkg.sv =====
// Package with the payload types, configuration codes and arithmetic helpers of the integrator.
`default_nettype none

package pei_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TIME_BITS = 16;
  localparam int KIN_STAGES = 5;
  localparam int FATE_STAGES = 3;

  localparam int LIFE_UP = (FRAC_BITS >= TIME_BITS) ? FRAC_BITS - TIME_BITS : 0;
  localparam int LIFE_DOWN = (FRAC_BITS < TIME_BITS) ? TIME_BITS - FRAC_BITS : 0;

  localparam logic [2:0] CFG_STEP_TIME = 3'd0;
  localparam logic [2:0] CFG_DAMPING = 3'd1;
  localparam logic [2:0] CFG_INV_MASS = 3'd2;
  localparam logic [2:0] CFG_USE_FORCES = 3'd3;
  localparam logic [2:0] CFG_SEMI = 3'd4;
  localparam logic [2:0] CFG_RADIUS = 3'd5;

  localparam logic [15:0] RST_STEP_TIME = 16'd1092;
  localparam logic [16:0] RST_DAMPING = 17'd65534;
  localparam logic [31:0] RST_INV_MASS = 32'd65536;
  localparam logic [16:0] DAMP_ONE = 17'd65536;
  localparam logic signed [31:0] LIFE_UNLIMITED = 32'sh7fffffff;
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic signed [31:0] push_z;
    logic signed [31:0] life_left;
  } pei_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_life_left;
    logic               still_active;
  } pei_out_t;

  typedef struct packed {
    logic [15:0] step_time;
    logic [16:0] damping;
    logic [31:0] inv_mass;
    logic        use_forces;
    logic        semi;
    logic [63:0] radius_limit;
  } pei_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > SAT_MAX) return SAT_MAX[31:0];
    if (x < SAT_MIN) return SAT_MIN[31:0];
    return x[31:0];
  endfunction

  function automatic logic [31:0] life_step(input logic [15:0] t);
    return (32'(t) << LIFE_UP) >> LIFE_DOWN;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pei_kin.sv =====
// Kinematics pipeline: acceleration, Euler step and velocity damping over five stages.
`default_nettype none

module pei_kin import pei_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pei_cfg_t           cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pei_in_t            in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pos [3],
  output logic signed [31:0]      out_vel [3],
  output logic signed [31:0]      out_life
);

  logic [KIN_STAGES-1:0] v_r, v_nxt, en;

  logic signed [31:0] s1_pos_nxt [3], s1_pos_r [3];
  logic signed [31:0] s1_vel_nxt [3], s1_vel_r [3];
  logic signed [31:0] s1_push_nxt [3], s1_push_r [3];
  logic signed [64:0] s1_pm_nxt [3], s1_pm_r [3];
  logic signed [48:0] s1_vt_nxt [3], s1_vt_r [3];
  logic signed [31:0] s1_life_nxt, s1_life_r;

  logic signed [31:0] acc [3];
  logic signed [33:0] pe_sum [3];
  logic signed [31:0] s2_pos_r [3], s2_vel_r [3], s2_pe_nxt [3], s2_pe_r [3];
  logic signed [48:0] s2_at_nxt [3], s2_at_r [3];
  logic signed [31:0] s2_life_r;

  logic signed [33:0] v1_sum [3];
  logic signed [31:0] s3_pos_r [3], s3_pe_r [3], s3_v1_nxt [3], s3_v1_r [3];
  logic signed [31:0] s3_life_r;

  logic signed [31:0] s4_pos_r [3], s4_pe_r [3];
  logic signed [48:0] s4_vt_nxt [3], s4_vt_r [3];
  logic signed [49:0] s4_vd_nxt [3], s4_vd_r [3];
  logic signed [31:0] s4_life_r;

  logic signed [33:0] p1_sum [3];
  logic signed [31:0] s5_pos_nxt [3], s5_pos_r [3], s5_vel_nxt [3], s5_vel_r [3];
  logic signed [31:0] s5_life_r;

  always_comb begin
    en[KIN_STAGES-1] = !v_r[KIN_STAGES-1] || out_ready;
    for (int i = KIN_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < KIN_STAGES; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_comb begin
    s1_pos_nxt[0] = in_data.pos_x;
    s1_pos_nxt[1] = in_data.pos_y;
    s1_pos_nxt[2] = in_data.pos_z;
    s1_vel_nxt[0] = in_data.vel_x;
    s1_vel_nxt[1] = in_data.vel_y;
    s1_vel_nxt[2] = in_data.vel_z;
    s1_push_nxt[0] = in_data.push_x;
    s1_push_nxt[1] = in_data.push_y;
    s1_push_nxt[2] = in_data.push_z;
    s1_life_nxt = in_data.life_left;
    for (int i = 0; i < 3; i++) begin
      s1_pm_nxt[i] = s1_push_nxt[i] * $signed({1'b0, cfg.inv_mass});
      s1_vt_nxt[i] = s1_vel_nxt[i] * $signed({1'b0, cfg.step_time});
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = cfg.use_forces ? sat32(64'(s1_pm_r[i] >>> FRAC_BITS)) : s1_push_r[i];
      s2_at_nxt[i] = acc[i] * $signed({1'b0, cfg.step_time});
      pe_sum[i] = 34'(s1_pos_r[i]) + 34'(s1_vt_r[i] >>> TIME_BITS);
      s2_pe_nxt[i] = sat32(64'(pe_sum[i]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v1_sum[i] = 34'(s2_vel_r[i]) + 34'(s2_at_r[i] >>> TIME_BITS);
      s3_v1_nxt[i] = sat32(64'(v1_sum[i]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_vt_nxt[i] = s3_v1_r[i] * $signed({1'b0, cfg.step_time});
      s4_vd_nxt[i] = s3_v1_r[i] * $signed({1'b0, cfg.damping});
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1_sum[i] = 34'(s4_pos_r[i]) + 34'(s4_vt_r[i] >>> TIME_BITS);
      s5_pos_nxt[i] = cfg.semi ? sat32(64'(p1_sum[i])) : s4_pe_r[i];
      s5_vel_nxt[i] = sat32(64'(s4_vd_r[i] >>> TIME_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1_pos_r[i] <= s1_pos_nxt[i];
        s1_vel_r[i] <= s1_vel_nxt[i];
        s1_push_r[i] <= s1_push_nxt[i];
        s1_pm_r[i] <= s1_pm_nxt[i];
        s1_vt_r[i] <= s1_vt_nxt[i];
      end
      s1_life_r <= s1_life_nxt;
    end
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s2_pos_r[i] <= s1_pos_r[i];
        s2_vel_r[i] <= s1_vel_r[i];
        s2_pe_r[i] <= s2_pe_nxt[i];
        s2_at_r[i] <= s2_at_nxt[i];
      end
      s2_life_r <= s1_life_r;
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        s3_pos_r[i] <= s2_pos_r[i];
        s3_pe_r[i] <= s2_pe_r[i];
        s3_v1_r[i] <= s3_v1_nxt[i];
      end
      s3_life_r <= s2_life_r;
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        s4_pos_r[i] <= s3_pos_r[i];
        s4_pe_r[i] <= s3_pe_r[i];
        s4_vt_r[i] <= s4_vt_nxt[i];
        s4_vd_r[i] <= s4_vd_nxt[i];
      end
      s4_life_r <= s3_life_r;
    end
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        s5_pos_r[i] <= s5_pos_nxt[i];
        s5_vel_r[i] <= s5_vel_nxt[i];
      end
      s5_life_r <= s4_life_r;
    end
  end

  assign in_ready = en[0];
  assign out_valid = v_r[KIN_STAGES-1];
  assign out_pos = s5_pos_r;
  assign out_vel = s5_vel_r;
  assign out_life = s5_life_r;

endmodule

`default_nettype wire

// ===== rtl/pei_fate.sv =====
// Retirement pipeline: squared distance, retire decision and life update over three stages.
`default_nettype none

module pei_fate import pei_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pei_cfg_t           cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_pos [3],
  input  wire logic signed [31:0] in_vel [3],
  input  wire logic signed [31:0] in_life,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pei_out_t                out_data
);

  logic [FATE_STAGES-1:0] v_r, v_nxt, en;

  logic signed [31:0] f1_pos_r [3], f1_vel_r [3], f1_life_r;
  logic signed [63:0] sq_prod [3];
  logic [63:0]        f1_sq_nxt [3], f1_sq_r [3];

  logic signed [31:0] f2_pos_r [3], f2_vel_r [3], f2_life_r;
  logic [63:0]        f2_sum_nxt, f2_sum_r;

  logic               active;
  logic signed [63:0] life_diff;
  pei_out_t           f3_out_nxt, f3_out_r;

  always_comb begin
    en[FATE_STAGES-1] = !v_r[FATE_STAGES-1] || out_ready;
    for (int i = FATE_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < FATE_STAGES; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_prod[i] = in_pos[i] * in_pos[i];
      f1_sq_nxt[i] = sq_prod[i];
    end
    f2_sum_nxt = f1_sq_r[0] + f1_sq_r[1] + f1_sq_r[2];
  end

  always_comb begin
    active = !(f2_pos_r[1] < 0 || f2_sum_r > cfg.radius_limit || f2_life_r < 0);
    life_diff = 64'(f2_life_r) - 64'({1'b0, life_step(cfg.step_time)});
    f3_out_nxt.new_pos_x = f2_pos_r[0];
    f3_out_nxt.new_pos_y = f2_pos_r[1];
    f3_out_nxt.new_pos_z = f2_pos_r[2];
    f3_out_nxt.new_vel_x = f2_vel_r[0];
    f3_out_nxt.new_vel_y = f2_vel_r[1];
    f3_out_nxt.new_vel_z = f2_vel_r[2];
    f3_out_nxt.still_active = active;
    if (active && f2_life_r != LIFE_UNLIMITED) begin
      f3_out_nxt.new_life_left = sat32(life_diff);
    end else begin
      f3_out_nxt.new_life_left = f2_life_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        f1_pos_r[i] <= in_pos[i];
        f1_vel_r[i] <= in_vel[i];
        f1_sq_r[i] <= f1_sq_nxt[i];
      end
      f1_life_r <= in_life;
    end
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        f2_pos_r[i] <= f1_pos_r[i];
        f2_vel_r[i] <= f1_vel_r[i];
      end
      f2_life_r <= f1_life_r;
      f2_sum_r <= f2_sum_nxt;
    end
    if (en[2]) begin
      f3_out_r <= f3_out_nxt;
    end
  end

  assign in_ready = en[0];
  assign out_valid = v_r[FATE_STAGES-1];
  assign out_data = f3_out_r;

endmodule

`default_nettype wire

// ===== rtl/particle_euler_integrator_top.sv =====
// Top level of the particle integrator: configuration registers and the two pipelines.
//
//   Channel  Signals                              Moves
//   in       in_valid, in_ready, in_data           one particle request
//   out      out_valid, out_ready, out_data        one updated particle
//   cfg      cfg_we, cfg_index, cfg_wdata          one register write
//
// One request enters per clock while in_ready is high; out_valid rises once a request has
// reached the last of the eight register stages: five for acceleration, Euler step and
// damping, three for squared distance, retire compare and life update.
// Reset clears only the stage valid bits and loads the register defaults; there is no sweep.
// A stall on out_ready holds only the run of full stages behind the output, so empty stages keep taking requests.
`default_nettype none

module particle_euler_integrator_top import pei_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire pei_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output pei_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  logic [15:0] step_time_r;
  logic [16:0] damping_r;
  logic [31:0] inv_mass_r;
  logic        use_forces_r;
  logic        semi_r;
  logic [63:0] radius_r;
  pei_cfg_t    cfg;

  logic               mid_valid, mid_ready;
  logic signed [31:0] mid_pos [3];
  logic signed [31:0] mid_vel [3];
  logic signed [31:0] mid_life;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= RST_STEP_TIME;
      damping_r <= RST_DAMPING;
      inv_mass_r <= RST_INV_MASS;
      use_forces_r <= 1'b1;
      semi_r <= 1'b0;
      radius_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_TIME: step_time_r <= cfg_wdata[15:0];
        CFG_DAMPING: damping_r <= cfg_wdata[16:0];
        CFG_INV_MASS: inv_mass_r <= cfg_wdata[31:0];
        CFG_USE_FORCES: use_forces_r <= cfg_wdata[0];
        CFG_SEMI: semi_r <= cfg_wdata[0];
        CFG_RADIUS: radius_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.step_time = step_time_r;
    cfg.damping = (damping_r > DAMP_ONE) ? DAMP_ONE : damping_r;
    cfg.inv_mass = inv_mass_r;
    cfg.use_forces = use_forces_r;
    cfg.semi = semi_r;
    cfg.radius_limit = radius_r;
  end

  pei_kin u_kin (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_pos   (mid_pos),
    .out_vel   (mid_vel),
    .out_life  (mid_life)
  );

  pei_fate u_fate (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_pos    (mid_pos),
    .in_vel    (mid_vel),
    .in_life   (mid_life),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/pei_chk.sv =====
// Port checker for the particle integrator and its bind to the top level.
`default_nettype none

module pei_chk import pei_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire pei_out_t out_data
);

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // An active particle never has a negative height.
  a_active_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.still_active |-> !out_data.new_pos_y[31])
    else $error("active particle below ground");

  // With the output stage empty the whole pipeline can move, so input is open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage is empty");

endmodule

bind particle_euler_integrator_top pei_chk u_chk (.*);

`default_nettype wire

// ===== dv/tb_particle_euler_integrator_top.sv =====
// Self-checking testbench for the particle integrator: directed and random requests checked against a built-in predictor.
module tb_particle_euler_integrator_top;
  import pei_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_SETTING = 210;
  localparam int SETTLE_CYCLES = 20;
  localparam int PAUSE_PHASE = 4;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef struct {
    pei_in_t  particle;
    bit       known;
    pei_out_t result;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pei_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pei_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  pei_cfg_t      regs_now;
  pei_cfg_t      settings[$];
  pei_out_t      awaited_updates[$];
  directed_row_t directed_rows[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int updates_checked = 0;
  int retired_seen = 0;
  int cycle_count = 0;

  particle_euler_integrator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d updates pending.", cycle_count,
               awaited_updates.size());
      $display("tb_particle_euler_integrator_top NOT OK");
      $finish;
    end
  end

  function automatic logic signed [63:0] clip32(input logic signed [63:0] x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  function automatic pei_out_t advance_particle(input pei_in_t p, input pei_cfg_t c);
    logic signed [63:0] pos [3];
    logic signed [63:0] vel [3];
    logic signed [63:0] acc [3];
    logic signed [63:0] push [3];
    logic signed [63:0] dt;
    logic signed [63:0] damp;
    logic signed [63:0] gain;
    logic signed [63:0] life;
    logic signed [63:0] life_after;
    logic [63:0] dist2;
    logic alive;
    pei_out_t r;
    pos[0] = p.pos_x;
    pos[1] = p.pos_y;
    pos[2] = p.pos_z;
    vel[0] = p.vel_x;
    vel[1] = p.vel_y;
    vel[2] = p.vel_z;
    push[0] = p.push_x;
    push[1] = p.push_y;
    push[2] = p.push_z;
    life = p.life_left;
    dt = $signed({48'd0, c.step_time});
    damp = (c.damping > DAMP_ONE) ? $signed({47'd0, DAMP_ONE}) : $signed({47'd0, c.damping});
    gain = $signed({32'd0, c.inv_mass});
    dist2 = '0;
    for (int i = 0; i < 3; i++) begin
      acc[i] = c.use_forces ? clip32((push[i] * gain) >>> FRAC_BITS) : push[i];
      if (c.semi) begin
        vel[i] = clip32(vel[i] + ((acc[i] * dt) >>> TIME_BITS));
        pos[i] = clip32(pos[i] + ((vel[i] * dt) >>> TIME_BITS));
      end else begin
        pos[i] = clip32(pos[i] + ((vel[i] * dt) >>> TIME_BITS));
        vel[i] = clip32(vel[i] + ((acc[i] * dt) >>> TIME_BITS));
      end
      vel[i] = clip32((vel[i] * damp) >>> TIME_BITS);
      dist2 += pos[i] * pos[i];
    end
    alive = !(pos[1] < 0 || dist2 > c.radius_limit || life < 0);
    life_after = (alive && life != Q_MAX) ? clip32(life - dt) : life;
    r.new_pos_x = pos[0][31:0];
    r.new_pos_y = pos[1][31:0];
    r.new_pos_z = pos[2][31:0];
    r.new_vel_x = vel[0][31:0];
    r.new_vel_y = vel[1][31:0];
    r.new_vel_z = vel[2][31:0];
    r.new_life_left = life_after[31:0];
    r.still_active = alive;
    return r;
  endfunction

  function automatic pei_in_t mk_particle(
    input logic signed [31:0] px, py, pz, vx, vy, vz, fx, fy, fz, life);
    return {px, py, pz, vx, vy, vz, fx, fy, fz, life};
  endfunction

  function automatic pei_out_t mk_update(
    input logic signed [31:0] px, py, pz, vx, vy, vz, life, input logic active);
    return {px, py, pz, vx, vy, vz, life, active};
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2097152)) - 1048576;
      2: return Q_MAX - $urandom_range(0, 255);
      3: return Q_MIN + $urandom_range(0, 255);
      4: return $signed($urandom_range(0, 33554432)) - 16777216;
      default: return $urandom_range(0, 2) - 1;
    endcase
  endfunction

  function automatic pei_in_t rand_particle();
    pei_in_t p;
    p.pos_x = rand_q();
    p.pos_y = rand_q();
    p.pos_z = rand_q();
    p.vel_x = rand_q();
    p.vel_y = rand_q();
    p.vel_z = rand_q();
    p.push_x = rand_q();
    p.push_y = rand_q();
    p.push_z = rand_q();
    if (p.pos_y < 0 && $urandom_range(99) < 70) p.pos_y = ~p.pos_y;
    case ($urandom_range(0, 9))
      0: p.life_left = Q_MAX;
      1: p.life_left = $urandom | 32'h8000_0000;
      2: p.life_left = $urandom_range(0, 2000);
      default: p.life_left = $urandom_range(0, 6553600);
    endcase
    return p;
  endfunction

  function automatic void flag_mismatch(input string field, input longint want,
                                        input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on update %0d, %s: expected %0d, got %0d", updates_checked, field,
               want, got);
  endfunction

  task automatic check_update(input pei_out_t got);
    pei_out_t want;
    if (awaited_updates.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Update %0d arrived with no request pending.", updates_checked);
    end else begin
      want = awaited_updates.pop_front();
      if (got.new_pos_x !== want.new_pos_x)
        flag_mismatch("new_pos_x", want.new_pos_x, got.new_pos_x);
      if (got.new_pos_y !== want.new_pos_y)
        flag_mismatch("new_pos_y", want.new_pos_y, got.new_pos_y);
      if (got.new_pos_z !== want.new_pos_z)
        flag_mismatch("new_pos_z", want.new_pos_z, got.new_pos_z);
      if (got.new_vel_x !== want.new_vel_x)
        flag_mismatch("new_vel_x", want.new_vel_x, got.new_vel_x);
      if (got.new_vel_y !== want.new_vel_y)
        flag_mismatch("new_vel_y", want.new_vel_y, got.new_vel_y);
      if (got.new_vel_z !== want.new_vel_z)
        flag_mismatch("new_vel_z", want.new_vel_z, got.new_vel_z);
      if (got.new_life_left !== want.new_life_left)
        flag_mismatch("new_life_left", want.new_life_left, got.new_life_left);
      if (got.still_active !== want.still_active)
        flag_mismatch("still_active", want.still_active, got.still_active);
    end
    updates_checked++;
    if (got.still_active === 1'b0) retired_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) check_update(out_data);
  end

  task automatic send_particle(input pei_in_t p, input pei_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_updates.push_back(want);
    requests_sent++;
  endtask

  task automatic drain_updates();
    in_valid <= 1'b0;
    while (awaited_updates.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input pei_in_t p, input bit known, input pei_out_t res);
    directed_row_t row;
    row.particle = p;
    row.known = known;
    row.result = res;
    directed_rows.push_back(row);
  endtask

  // Upper bits above each register's width carry junk; the spare indexes go last.
  task automatic load_settings(input pei_cfg_t s);
    logic [63:0] field_val [8];
    field_val[CFG_STEP_TIME] = {$urandom, 16'($urandom), s.step_time};
    field_val[CFG_DAMPING] = {$urandom, 15'($urandom), s.damping};
    field_val[CFG_INV_MASS] = {$urandom, s.inv_mass};
    field_val[CFG_USE_FORCES] = {$urandom, 31'($urandom), s.use_forces};
    field_val[CFG_SEMI] = {$urandom, 31'($urandom), s.semi};
    field_val[CFG_RADIUS] = s.radius_limit;
    field_val[CFG_SPARE_LO] = {$urandom, $urandom};
    field_val[CFG_SPARE_HI] = {$urandom, $urandom};
    for (int idx = 0; idx < 8; idx++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(idx);
      cfg_wdata <= field_val[idx];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    regs_now = s;
  endtask

  initial begin
    pei_in_t particle;
    regs_now = {RST_STEP_TIME, RST_DAMPING, RST_INV_MASS, 1'b1, 1'b0, {64{1'b1}}};

    add_row(mk_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_update(0, 0, 0, 0, 0, 0, -1092, 1'b1));
    add_row(mk_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, -1), 1'b1,
            mk_update(0, 0, 0, 0, 0, 0, -1, 1'b0));
    add_row(mk_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, Q_MAX), 1'b1,
            mk_update(0, 0, 0, 0, 0, 0, Q_MAX, 1'b1));
    add_row(mk_particle(0, -Q_ONE, 0, 0, 0, 0, 0, 0, 0, Q_ONE), 1'b1,
            mk_update(0, -Q_ONE, 0, 0, 0, 0, Q_ONE, 1'b0));
    add_row(mk_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, Q_MIN), 1'b1,
            mk_update(0, 0, 0, 0, 0, 0, Q_MIN, 1'b0));
    add_row(mk_particle(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX),
            1'b0, '0);
    add_row(mk_particle(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
            1'b0, '0);
    add_row(mk_particle(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_ONE),
            1'b0, '0);
    add_row(mk_particle(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1),
            1'b0, '0);
    add_row(mk_particle(0, 10 * Q_ONE, 0, Q_ONE, Q_ONE, -Q_ONE, 0, -642908, 0, 5 * Q_ONE),
            1'b0, '0);
    add_row(mk_particle(0, Q_ONE, 0, 0, 0, 0, Q_MAX, Q_MAX, Q_MIN, Q_ONE), 1'b0, '0);
    add_row(mk_particle(0, 0, 0, -1, -1, -1, 0, 0, 0, Q_ONE), 1'b0, '0);
    add_row(mk_particle(0, 0, 0, 0, 0, 0, -1, -1, -1, Q_ONE), 1'b0, '0);
    add_row(mk_particle(Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 0, 1092), 1'b0, '0);
    add_row(mk_particle(Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 0, 1091), 1'b0, '0);
    add_row(mk_particle(32'h5555_5555, 32'h2aaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                        32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                        32'haaaa_aaaa, 32'h5555_5555), 1'b0, '0);

    settings.push_back({RST_STEP_TIME, RST_DAMPING, RST_INV_MASS, 1'b1, 1'b0, {64{1'b1}}});
    settings.push_back({16'd0, DAMP_ONE, 32'd0, 1'b1, 1'b1, 64'd0});
    settings.push_back({16'hffff, 17'h1_ffff, 32'hffff_ffff, 1'b1, 1'b0, {64{1'b1}}});
    settings.push_back({16'd1, 17'd0, 32'd1, 1'b0, 1'b1, {$urandom, $urandom}});
    settings.push_back({16'($urandom_range(1, 65535)), 17'd65537, 32'($urandom), 1'b0, 1'b0,
                        {$urandom, $urandom}});
    settings.push_back({16'hffff, DAMP_ONE, 32'd65536, 1'b0, 1'b1, 64'h0000_0100_0000_0000});
    settings.push_back({16'($urandom_range(1, 65535)), 17'($urandom_range(0, 131071)),
                        32'($urandom), 1'($urandom), 1'($urandom), {$urandom, $urandom}});
    settings.push_back({16'd4096, 17'd60000, 32'd196608, 1'b1, 1'b1, 64'h0000_1000_0000_0000});
    settings.push_back({RST_STEP_TIME, RST_DAMPING, RST_INV_MASS, 1'b0, 1'b0, {64{1'b1}}});

    send_idle_pct = 30;
    recv_idle_pct = 75;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_particle(directed_rows[i].particle,
                    directed_rows[i].known ? directed_rows[i].result
                                           : advance_particle(directed_rows[i].particle,
                                                              regs_now));
    end
    drain_updates();

    for (int phase = 0; phase < settings.size(); phase++) begin
      send_idle_pct = (phase < 3) ? 30 : (phase < 6) ? 75 : 0;
      recv_idle_pct = (phase < 3) ? 75 : (phase < 6) ? 30 : 0;
      load_settings(settings[phase]);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (phase == PAUSE_PHASE && n == ITEMS_PER_SETTING / 2) drain_updates();
        particle = rand_particle();
        send_particle(particle, advance_particle(particle, regs_now));
      end
      drain_updates();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d particle requests (%0d directed) over reset values and %0d settings.",
             requests_sent, directed_rows.size(), settings.size());
    $display("Checked %0d updates, %0d of them retiring the particle; %0d mismatches.",
             updates_checked, retired_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_particle_euler_integrator_top OK");
    end else begin
      $display("tb_particle_euler_integrator_top NOT OK");
    end
    $finish;
  end

endmodule
